// ----- hw/rtl/ssdf_pkg.sv -----
// ----------------------------------------------------------------------------
// Sphere SDF package
// Shared widths, stage counts and the records carried along the cell rows.
// ----------------------------------------------------------------------------
`default_nettype none
package ssdf_pkg;
	localparam int COORD_BITS     = 24;
	localparam int GRAD_FRAC_BITS = 16;
	localparam int RADIUS_BITS    = 23;
	localparam int DIST_BITS      = 25;
	localparam int GRAD_BITS      = 18;
	localparam int SQ_BITS        = 2 * COORD_BITS;
	localparam int ROOT_BITS      = COORD_BITS;
	localparam int REM_BITS       = ROOT_BITS + 2;
	localparam int QUO_BITS       = GRAD_FRAC_BITS + 1;
	localparam int SQRT_CELLS     = ROOT_BITS;
	localparam int DIV_CELLS      = QUO_BITS;

	typedef logic [COORD_BITS-1:0] mag_t;
	typedef mag_t [2:0] mag3_t;

	typedef struct packed {
		mag3_t      mag;
		logic [2:0] neg;
	} sqrt_ctx_t;

	typedef struct packed {
		logic [SQ_BITS-1:0]   rad;
		logic [REM_BITS-1:0]  rem;
		logic [ROOT_BITS-1:0] root;
		sqrt_ctx_t            ctx;
	} sqrt_data_t;

	typedef struct packed {
		logic signed [DIST_BITS-1:0] dist_val;
		logic [2:0]                  neg;
		logic                        zero;
	} div_ctx_t;

	typedef struct packed {
		logic [ROOT_BITS-1:0]            den;
		logic [2:0][ROOT_BITS-1:0]       rem;
		logic [2:0][QUO_BITS-1:0]        bits;
		logic [2:0][QUO_BITS-1:0]        quo;
		div_ctx_t                        ctx;
	} div_data_t;
endpackage
`default_nettype wire

// ----- hw/rtl/sphere_sdf_value_and_gradient.sv -----
// ----------------------------------------------------------------------------
// Sphere signed distance with gradient
// Distance of a point to an origin-centered sphere and the unit gradient.
// ----------------------------------------------------------------------------
// The slave channel takes one point per beat, x, y and z in signed Q12.12.
// The master channel gives one beat per point: the distance (length minus
// radius, Q13.12) and the gradient, each coordinate over the length in Q2.16.
// A point at the origin gives a zero gradient.
// cfg_we and cfg_data write the radius register (reset sets 1.0); the user must
// write it only while no point is in flight, which the block does not enforce.
// From an accepted input beat to its output beat the point passes a register
// each for magnitudes, squares and their sum, 24 square root cells of one
// bit each, a register for the distance, 17 divider cells of one quotient
// bit each and the output register.
// Throughput is one point per cycle. The whole row of cells advances
// together; when the receiver stalls with a beat held in the output
// register, s_tready drops and every stage holds.
// Reset clears all valid flags, so the block comes up empty.
// ----------------------------------------------------------------------------
`default_nettype none
module sphere_sdf_value_and_gradient import ssdf_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [71:0] s_tdata,  // pos_x, pos_y, pos_z
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [79:0] m_tdata,  // distance, grad_x, grad_y, grad_z, zero pad
	input  wire         cfg_we,
	input  wire  [22:0] cfg_data
);
	localparam int NSTG = 3 + SQRT_CELLS + 1 + DIV_CELLS + 1;

	logic                   adv;
	logic [NSTG-1:0]        vld_q;
	logic [RADIUS_BITS-1:0] radius_q;
	mag3_t                  mag_s1;
	logic [2:0]             neg_s1;
	logic [2:0][SQ_BITS-1:0] sq_s2;
	sqrt_ctx_t              ctx_s2;
	sqrt_data_t             sqrt_d [SQRT_CELLS+1];
	div_data_t              div_d [DIV_CELLS+1];
	logic [2:0][GRAD_BITS-1:0] grad_w;
	logic [COORD_BITS-1:0]  raw [3];

	assign adv      = !vld_q[NSTG-1] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			radius_q <= RADIUS_BITS'(4096);
		end else begin
			if (cfg_we) begin
				radius_q <= cfg_data;
			end
			if (adv) begin
				vld_q <= {vld_q[NSTG-2:0], s_tvalid};
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			raw[i] = s_tdata[i*COORD_BITS +: COORD_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= raw[i][COORD_BITS-1];
				mag_s1[i] <= raw[i][COORD_BITS-1] ? (~raw[i] + 1'b1) : raw[i];
				sq_s2[i]  <= mag_s1[i] * mag_s1[i];
			end
			ctx_s2.mag <= mag_s1;
			ctx_s2.neg <= neg_s1;
			sqrt_d[0].rad  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			sqrt_d[0].rem  <= '0;
			sqrt_d[0].root <= '0;
			sqrt_d[0].ctx  <= ctx_s2;
		end
	end

	for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
		ssdf_sqrt_cell u_cell (
			.clk (clk),
			.en  (adv),
			.din (sqrt_d[g]),
			.dout(sqrt_d[g+1])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_d[0].den <= sqrt_d[SQRT_CELLS].root;
			for (int i = 0; i < 3; i++) begin
				div_d[0].rem[i]  <= ROOT_BITS'(sqrt_d[SQRT_CELLS].ctx.mag[i][COORD_BITS-1:1]);
				div_d[0].bits[i] <= {sqrt_d[SQRT_CELLS].ctx.mag[i][0],
					(QUO_BITS-1)'(0)};
				div_d[0].quo[i]  <= '0;
			end
			div_d[0].ctx.dist_val <= $signed({1'b0, sqrt_d[SQRT_CELLS].root})
				- $signed({2'b00, radius_q});
			div_d[0].ctx.neg  <= sqrt_d[SQRT_CELLS].ctx.neg;
			div_d[0].ctx.zero <= (sqrt_d[SQRT_CELLS].root == '0);
		end
	end

	for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
		ssdf_div_cell u_cell (
			.clk (clk),
			.en  (adv),
			.din (div_d[g]),
			.dout(div_d[g+1])
		);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (div_d[DIV_CELLS].ctx.zero) begin
				grad_w[i] = '0;
			end else if (div_d[DIV_CELLS].ctx.neg[i]) begin
				grad_w[i] = GRAD_BITS'(-{1'b0, div_d[DIV_CELLS].quo[i]});
			end else begin
				grad_w[i] = GRAD_BITS'({1'b0, div_d[DIV_CELLS].quo[i]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {1'b0, grad_w[2], grad_w[1], grad_w[0],
				div_d[DIV_CELLS].ctx.dist_val};
		end
	end

`ifndef SYNTHESIS
	a_grad_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[42:25]) <= 18'sd65536 &&
			$signed(m_tdata[42:25]) >= -18'sd65536))
		else $error("grad_x beyond unit magnitude");
	a_grad_z_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[78:61]) <= 18'sd65536 &&
			$signed(m_tdata[78:61]) >= -18'sd65536))
		else $error("grad_z beyond unit magnitude");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv) |=> $stable(vld_q))
		else $error("pipeline moved while stalled");
`endif
endmodule
`default_nettype wire

// ----- hw/rtl/ssdf_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// Square root cell
// Per enabled cycle, settles one root bit; partial root passes to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module ssdf_sqrt_cell import ssdf_pkg::*; (
	input  wire        clk,
	input  wire        en,
	input  sqrt_data_t din,
	output sqrt_data_t dout
);
	logic [REM_BITS+1:0] rem_w;
	logic [REM_BITS+1:0] trial;
	sqrt_data_t          nxt;

	always_comb begin
		rem_w = {din.rem, din.rad[SQ_BITS-1 -: 2]};
		trial = {2'b00, din.root, 2'b01};
		nxt = din;
		nxt.rad = {din.rad[SQ_BITS-3:0], 2'b00};
		if (rem_w >= trial) begin
			nxt.rem  = REM_BITS'(rem_w - trial);
			nxt.root = {din.root[ROOT_BITS-2:0], 1'b1};
		end else begin
			nxt.rem  = REM_BITS'(rem_w);
			nxt.root = {din.root[ROOT_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/ssdf_div_cell.sv -----
// ----------------------------------------------------------------------------
// Divider cell
// Per enabled cycle, settles one quotient bit in each of the 3 gradient lanes.
// ----------------------------------------------------------------------------
`default_nettype none
module ssdf_div_cell import ssdf_pkg::*; (
	input  wire       clk,
	input  wire       en,
	input  div_data_t din,
	output div_data_t dout
);
	logic [ROOT_BITS:0] rem_w [3];
	div_data_t          nxt;

	always_comb begin
		nxt = din;
		for (int i = 0; i < 3; i++) begin
			rem_w[i] = {din.rem[i], din.bits[i][QUO_BITS-1]};
			nxt.bits[i] = {din.bits[i][QUO_BITS-2:0], 1'b0};
			if (rem_w[i] >= {1'b0, din.den}) begin
				nxt.rem[i] = ROOT_BITS'(rem_w[i] - {1'b0, din.den});
				nxt.quo[i] = {din.quo[i][QUO_BITS-2:0], 1'b1};
			end else begin
				nxt.rem[i] = ROOT_BITS'(rem_w[i]);
				nxt.quo[i] = {din.quo[i][QUO_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end
endmodule
`default_nettype wire

// ----- tb/sphere_sdf_value_and_gradient_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sphere SDF stream checker
// Watches both stream channels and the radius write port. It predicts the
// distance and unit gradient of every accepted point and compares them with
// the output beats, in order.
// ----------------------------------------------------------------------------
`default_nettype none
module sphere_sdf_value_and_gradient_checker import ssdf_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [71:0] s_tdata,
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [79:0] m_tdata,
	input  wire         cfg_we,
	input  wire  [22:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          results_seen
);
	typedef struct packed {
		logic signed [DIST_BITS-1:0] distance;
		logic signed [GRAD_BITS-1:0] grad_x;
		logic signed [GRAD_BITS-1:0] grad_y;
		logic signed [GRAD_BITS-1:0] grad_z;
	} sdf_result_t;

	logic [RADIUS_BITS-1:0] radius_q;
	sdf_result_t            sdf_expected_q[$];

	function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
		logic [63:0] res;
		logic [63:0] bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n   = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [GRAD_BITS-1:0] unit_component(input logic [63:0] mag,
			input logic neg, input logic [63:0] len);
		logic [63:0] q;
		if (len == 0)
			return '0;
		q = (mag << GRAD_FRAC_BITS) / len;
		if (neg) begin
			if (q > (64'd1 << (GRAD_BITS - 1)))
				q = 64'd1 << (GRAD_BITS - 1);
			return GRAD_BITS'(-q);
		end
		if (q > (64'd1 << (GRAD_BITS - 1)) - 1)
			q = (64'd1 << (GRAD_BITS - 1)) - 1;
		return GRAD_BITS'(q);
	endfunction

	function automatic sdf_result_t sphere_field(input logic [71:0] point,
			input logic [RADIUS_BITS-1:0] radius);
		logic signed [COORD_BITS-1:0] c;
		logic [63:0] mag[3];
		logic        neg[3];
		logic [63:0] sum;
		logic [63:0] len;
		longint      d;
		sdf_result_t r;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			c      = point[i*COORD_BITS +: COORD_BITS];
			neg[i] = c[COORD_BITS-1];
			mag[i] = neg[i] ? 64'(-longint'(c)) : 64'(c);
			sum    = sum + mag[i] * mag[i];
		end
		len = floor_sqrt(sum);
		d   = longint'(len) - longint'(radius);
		if (d > (longint'(1) << (DIST_BITS - 1)) - 1)
			d = (longint'(1) << (DIST_BITS - 1)) - 1;
		if (d < -(longint'(1) << (DIST_BITS - 1)))
			d = -(longint'(1) << (DIST_BITS - 1));
		r.distance = DIST_BITS'(d);
		r.grad_x   = unit_component(mag[0], neg[0], len);
		r.grad_y   = unit_component(mag[1], neg[1], len);
		r.grad_z   = unit_component(mag[2], neg[2], len);
		return r;
	endfunction

	assign pending = sdf_expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		sdf_result_t want;
		sdf_result_t got;
		if (!arst_n) begin
			radius_q     <= 23'd4096;
			fail_count   <= 0;
			results_seen <= 0;
			sdf_expected_q.delete();
		end else begin
			if (cfg_we)
				radius_q <= cfg_data;
			if (s_tvalid && s_tready)
				sdf_expected_q.push_back(sphere_field(s_tdata, radius_q));
			if (m_tvalid && m_tready) begin
				got = m_tdata[DIST_BITS+3*GRAD_BITS-1:0];
				got = {m_tdata[DIST_BITS-1:0], m_tdata[DIST_BITS +: GRAD_BITS],
					m_tdata[DIST_BITS+GRAD_BITS +: GRAD_BITS],
					m_tdata[DIST_BITS+2*GRAD_BITS +: GRAD_BITS]};
				results_seen <= results_seen + 1;
				if (sdf_expected_q.size() == 0) begin
					$error("output beat with no point outstanding");
					fail_count <= fail_count + 1;
				end else begin
					want = sdf_expected_q.pop_front();
					if (got.distance !== want.distance)
						$error("distance: expected %0d, got %0d", want.distance, got.distance);
					if (got.grad_x !== want.grad_x)
						$error("grad_x: expected %0d, got %0d", want.grad_x, got.grad_x);
					if (got.grad_y !== want.grad_y)
						$error("grad_y: expected %0d, got %0d", want.grad_y, got.grad_y);
					if (got.grad_z !== want.grad_z)
						$error("grad_z: expected %0d, got %0d", want.grad_z, got.grad_z);
					if (got !== want)
						fail_count <= fail_count + 1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- tb/sphere_sdf_value_and_gradient_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sphere SDF testbench
// Drives points with random gaps and back-pressure through several radius
// settings, directed corner points first, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none
module sphere_sdf_value_and_gradient_tb;
	localparam int LATENCY   = 46;
	localparam int IDLE_CAP  = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic        cfg_we;
	logic [22:0] cfg_data;
	int          fail_count;
	int          pending;
	int          results_seen;
	int          sender_idle_pct;
	int          receiver_idle_pct;
	bit          hold_off;
	int          quiet_cycles = 0;
	int          points_sent;

	sphere_sdf_value_and_gradient dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	sphere_sdf_value_and_gradient_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .results_seen(results_seen)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		if (hold_off)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > IDLE_CAP) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [23:0] pick_coord();
		case ($urandom_range(7))
			0: return 24'h800000;
			1: return 24'h7fffff;
			2: return 24'(signed'($urandom_range(8192)) - 4096);
			3: return 24'(signed'($urandom_range(131072)) - 65536);
			4: return 24'h0;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_point(input logic [23:0] x, input logic [23:0] y,
			input logic [23:0] z);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {z, y, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		points_sent++;
	endtask

	task automatic drain_and_set_radius(input logic [22:0] r);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= r;
		@(posedge clk);
		cfg_we   <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [22:0] radii[6];
		arst_n            = 1'b0;
		s_tvalid          = 1'b0;
		s_tdata           = '0;
		cfg_we            = 1'b0;
		cfg_data          = '0;
		m_tready          = 1'b0;
		hold_off          = 1'b0;
		points_sent       = 0;
		sender_idle_pct   = 12;
		receiver_idle_pct = 12;
		radii = '{23'd0, 23'h7fffff, 23'd4096, 23'd1, 23'h400000, 23'd12345};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners at the reset radius: origin, extremes, axes, all-ones.
		send_point(24'h0, 24'h0, 24'h0);
		send_point(24'h800000, 24'h800000, 24'h800000);
		send_point(24'h7fffff, 24'h7fffff, 24'h7fffff);
		send_point(24'h800000, 24'h0, 24'h0);
		send_point(24'h0, 24'h7fffff, 24'h0);
		send_point(24'h0, 24'h0, 24'h800000);
		send_point(24'h001000, 24'h0, 24'h0);
		send_point(24'hfff000, 24'h0, 24'h0);
		send_point(24'hffffff, 24'hffffff, 24'hffffff);
		send_point(24'h000001, 24'h000001, 24'h000001);
		send_point(24'h555555, 24'haaaaaa, 24'h123456);
		send_point(24'h800000, 24'h7fffff, 24'h000001);
		send_point(24'h000003, 24'h000004, 24'h0);

		for (int phase = 0; phase < 6; phase++) begin
			drain_and_set_radius(radii[phase]);
			sender_idle_pct   = (phase == 2) ? 0 : 12;
			receiver_idle_pct = (phase == 2) ? 0 : 12;
			if (phase == 1) begin
				fork
					begin
						hold_off = 1'b1;
						repeat (300) @(posedge clk);
						hold_off = 1'b0;
					end
					for (int i = 0; i < 120; i++)
						send_point(pick_coord(), pick_coord(), pick_coord());
				join
			end
			for (int i = 0; i < 260; i++)
				send_point(pick_coord(), pick_coord(), pick_coord());
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
		$display("Covered %0d points and %0d results over six radius settings,",
			points_sent, results_seen);
		$display("including origin, full-scale corners, stalls and a long hold-off.");
		if (fail_count == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire
